### sv/qsc_pkg.sv
// ---------------------------------------------------------------------------
// qsc_pkg: shared types and constants for the quad shape classifier
// Register map, reset values, shape kind codes and the configuration bundle.
// ---------------------------------------------------------------------------
package qsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int AREA_W     = 24;
    localparam int COS_W      = 16;
    localparam int RATIO_W    = 20;
    // Both limits are fixed point with 16 fraction bits, so their squares carry 32.
    localparam int FRAC2_SHIFT = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COSINE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_HIGH    = 3'd6;

    localparam logic [1:0] KIND_SQUARE  = 2'd0;
    localparam logic [1:0] KIND_RED     = 2'd1;
    localparam logic [1:0] KIND_GRAY    = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [AREA_W-1:0]  RST_MIN_AREA     = 24'd1000;
    localparam logic [COS_W-1:0]   RST_COSINE_LIMIT = 16'd6554;
    localparam logic [RATIO_W-1:0] RST_SQUARE_MAX   = 20'd78643;
    localparam logic [RATIO_W-1:0] RST_RED_LOW      = 20'd85197;
    localparam logic [RATIO_W-1:0] RST_RED_HIGH     = 20'd98304;
    localparam logic [RATIO_W-1:0] RST_GRAY_LOW     = 20'd131072;
    localparam logic [RATIO_W-1:0] RST_GRAY_HIGH    = 20'd144179;

    typedef struct packed {
        logic [AREA_W-1:0]  min_area;
        logic [COS_W-1:0]   cosine_limit;
        logic [RATIO_W-1:0] square_ratio_max;
        logic [RATIO_W-1:0] red_ratio_low;
        logic [RATIO_W-1:0] red_ratio_high;
        logic [RATIO_W-1:0] gray_ratio_low;
        logic [RATIO_W-1:0] gray_ratio_high;
    } qsc_cfg_t;

endpackage

### sv/qsc_if.sv
// ---------------------------------------------------------------------------
// qsc interfaces: contour input, result output and register write channels
// Each channel is a valid/ready handshake with source and sink modports.
// ---------------------------------------------------------------------------
interface qsc_in_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [3:0]            vertex_count;
    logic [1:0]            shape_kind;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] x2;
    logic [COORD_BITS-1:0] y2;
    logic [COORD_BITS-1:0] x3;
    logic [COORD_BITS-1:0] y3;

    modport source (output valid, vertex_count, shape_kind, x0, y0, x1, y1, x2, y2, x3, y3,
                    input ready);
    modport sink (input valid, vertex_count, shape_kind, x0, y0, x1, y1, x2, y2, x3, y3,
                  output ready);
endinterface

interface qsc_out_if;
    logic valid;
    logic ready;
    logic is_match;
    logic area_ok;
    logic convex_ok;
    logic corners_ok;
    logic ratio_ok;

    modport source (output valid, is_match, area_ok, convex_ok, corners_ok, ratio_ok,
                    input ready);
    modport sink (input valid, is_match, area_ok, convex_ok, corners_ok, ratio_ok,
                  output ready);
endinterface

interface qsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/quad_shape_classifier.sv
// Path from input transaction to result: 3 front stages, queue, 3 back stages.
// Throughput: one contour per cycle while out_ch.ready is high; both ends are pipelined.
// The queue lets the front end keep accepting while the result register is stalled.
// Reset: asynchronous, active low; registers return to defaults, pipeline and queue empty.
// ---------------------------------------------------------------------------
// quad_shape_classifier: top level of the quadrilateral shape classifier
// Holds the configuration registers and joins front end, queue and back end.
// ---------------------------------------------------------------------------
module quad_shape_classifier
    import qsc_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int QDEPTH     = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    qsc_in_if.sink     in_ch,
    qsc_out_if.source  out_ch,
    qsc_cfg_if.sink    cfg_ch
);

    localparam int C  = COORD_BITS;
    localparam int LW = 2 * C + 1;
    localparam int QW = 1 + 2 + (2 * C + 2) + 1 + 3 * LW + 4 * LW;

    qsc_cfg_t cfg_reg;

    logic [3:0][C-1:0]  xs, ys;
    logic               f_valid, q_ready;
    logic               f_cnt, f_convex;
    logic [1:0]         f_kind;
    logic [2*C+1:0]     f_area;
    logic [2:0][LW-1:0] f_dot;
    logic [3:0][LW-1:0] f_len;

    logic [QW-1:0]      q_wdata, q_rdata;
    logic               q_valid, b_ready;

    logic               b_cnt, b_convex;
    logic [1:0]         b_kind;
    logic [2*C+1:0]     b_area;
    logic [2:0][LW-1:0] b_dot;
    logic [3:0][LW-1:0] b_len;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_area         <= RST_MIN_AREA;
            cfg_reg.cosine_limit     <= RST_COSINE_LIMIT;
            cfg_reg.square_ratio_max <= RST_SQUARE_MAX;
            cfg_reg.red_ratio_low    <= RST_RED_LOW;
            cfg_reg.red_ratio_high   <= RST_RED_HIGH;
            cfg_reg.gray_ratio_low   <= RST_GRAY_LOW;
            cfg_reg.gray_ratio_high  <= RST_GRAY_HIGH;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_MIN_AREA:     cfg_reg.min_area         <= cfg_ch.data[AREA_W-1:0];
                REG_COSINE_LIMIT: cfg_reg.cosine_limit     <= cfg_ch.data[COS_W-1:0];
                REG_SQUARE_MAX:   cfg_reg.square_ratio_max <= cfg_ch.data[RATIO_W-1:0];
                REG_RED_LOW:      cfg_reg.red_ratio_low    <= cfg_ch.data[RATIO_W-1:0];
                REG_RED_HIGH:     cfg_reg.red_ratio_high   <= cfg_ch.data[RATIO_W-1:0];
                REG_GRAY_LOW:     cfg_reg.gray_ratio_low   <= cfg_ch.data[RATIO_W-1:0];
                REG_GRAY_HIGH:    cfg_reg.gray_ratio_high  <= cfg_ch.data[RATIO_W-1:0];
                default:          cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign xs = {in_ch.x3, in_ch.x2, in_ch.x1, in_ch.x0};
    assign ys = {in_ch.y3, in_ch.y2, in_ch.y1, in_ch.y0};

    qsc_front #(.C(C)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .vertex_count (in_ch.vertex_count),
        .shape_kind   (in_ch.shape_kind),
        .xs           (xs),
        .ys           (ys),
        .out_valid    (f_valid),
        .out_ready    (q_ready),
        .count_ok     (f_cnt),
        .kind         (f_kind),
        .area_abs     (f_area),
        .convex       (f_convex),
        .dot_abs      (f_dot),
        .len_sq       (f_len)
    );

    assign q_wdata = {f_cnt, f_kind, f_area, f_convex, f_dot, f_len};

    qsc_fifo #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (q_ready),
        .in_data   (q_wdata),
        .out_valid (q_valid),
        .out_ready (b_ready),
        .out_data  (q_rdata)
    );

    assign {b_cnt, b_kind, b_area, b_convex, b_dot, b_len} = q_rdata;

    qsc_back #(.C(C)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (q_valid),
        .in_ready   (b_ready),
        .count_ok   (b_cnt),
        .kind       (b_kind),
        .area_abs   (b_area),
        .convex     (b_convex),
        .dot_abs    (b_dot),
        .len_sq     (b_len),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .is_match   (out_ch.is_match),
        .area_ok    (out_ch.area_ok),
        .convex_ok  (out_ch.convex_ok),
        .corners_ok (out_ch.corners_ok),
        .ratio_ok   (out_ch.ratio_ok)
    );

`ifndef NO_ASSERTIONS
    // A match must be backed by every individual test.
    a_match_implies_tests: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.is_match |->
            out_ch.area_ok && out_ch.convex_ok && out_ch.corners_ok && out_ch.ratio_ok)
        else $error("match reported without all tests passing");

    // The front end keeps its finished transaction while the queue is full.
    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !q_ready |=> f_valid && $stable(q_wdata))
        else $error("front end lost a transaction while the queue was full");
`endif

endmodule

### sv/qsc_front.sv
// ---------------------------------------------------------------------------
// qsc_front: geometry front end
// Three stall-together stages: capture, edge products, sums. Produces the
// doubled shoelace area, the convexity flag, corner dot magnitudes and squared side lengths.
// ---------------------------------------------------------------------------
module qsc_front
    import qsc_pkg::*;
#(
    parameter int C = 12
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3:0]               vertex_count,
    input  logic [1:0]               shape_kind,
    input  logic [3:0][C-1:0]        xs,
    input  logic [3:0][C-1:0]        ys,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     count_ok,
    output logic [1:0]               kind,
    output logic [2*C+1:0]           area_abs,
    output logic                     convex,
    output logic [2:0][2*C:0]        dot_abs,
    output logic [3:0][2*C:0]        len_sq
);

    localparam int PW = 2 * C + 2;
    localparam int SW = 2 * C + 3;
    localparam int LW = 2 * C + 1;

    logic          en;
    logic          v1_reg, v2_reg, v3_reg;

    logic          cnt1_reg, cnt2_reg;
    logic [1:0]    kind1_reg, kind2_reg;
    logic [C-1:0]  x1_reg [4];
    logic [C-1:0]  y1_reg [4];

    logic signed [C:0]    ex [4];
    logic signed [C:0]    ey [4];
    logic [2*C-1:0]       spa [4];
    logic [2*C-1:0]       spb [4];
    logic signed [PW-1:0] cpa [4];
    logic signed [PW-1:0] cpb [4];
    logic signed [PW-1:0] sqx [4];
    logic signed [PW-1:0] sqy [4];
    logic signed [PW-1:0] dxx [3];
    logic signed [PW-1:0] dyy [3];

    logic [2*C-1:0]       spa_reg [4];
    logic [2*C-1:0]       spb_reg [4];
    logic signed [PW-1:0] cpa_reg [4];
    logic signed [PW-1:0] cpb_reg [4];
    logic [2*C-1:0]       sqx_reg [4];
    logic [2*C-1:0]       sqy_reg [4];
    logic signed [PW-1:0] dxx_reg [3];
    logic signed [PW-1:0] dyy_reg [3];

    logic signed [SW-1:0] s_sum;
    logic signed [SW-1:0] s_abs;
    logic                 convex_c;
    logic [2:0][LW-1:0]   dot_c;
    logic [3:0][LW-1:0]   len_c;

    logic                 cnt3_reg;
    logic [1:0]           kind3_reg;
    logic [2*C+1:0]       area3_reg;
    logic                 convex3_reg;
    logic [2:0][LW-1:0]   dot3_reg;
    logic [3:0][LW-1:0]   len3_reg;

    assign en       = !v3_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Edge k runs from vertex k to vertex k+1; corners and turns use neighboring edges.
    always_comb
    begin
        int n;
        int p;
        for (int k = 0; k < 4; k++)
        begin
            n = (k + 1) & 3;
            ex[k] = $signed({1'b0, x1_reg[n]}) - $signed({1'b0, x1_reg[k]});
            ey[k] = $signed({1'b0, y1_reg[n]}) - $signed({1'b0, y1_reg[k]});
        end
        for (int k = 0; k < 4; k++)
        begin
            n = (k + 1) & 3;
            p = (k + 3) & 3;
            spa[k] = x1_reg[k] * y1_reg[n];
            spb[k] = x1_reg[n] * y1_reg[k];
            cpa[k] = ex[p] * ey[k];
            cpb[k] = ey[p] * ex[k];
            sqx[k] = ex[k] * ex[k];
            sqy[k] = ey[k] * ey[k];
        end
        for (int c = 0; c < 3; c++)
        begin
            dxx[c] = ex[c+1] * ex[c];
            dyy[c] = ey[c+1] * ey[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt1_reg  <= (vertex_count == 4'd4);
            kind1_reg <= shape_kind;
            for (int k = 0; k < 4; k++)
            begin
                x1_reg[k] <= xs[k];
                y1_reg[k] <= ys[k];
            end
            cnt2_reg  <= cnt1_reg;
            kind2_reg <= kind1_reg;
            for (int k = 0; k < 4; k++)
            begin
                spa_reg[k] <= spa[k];
                spb_reg[k] <= spb[k];
                cpa_reg[k] <= cpa[k];
                cpb_reg[k] <= cpb[k];
                sqx_reg[k] <= sqx[k][2*C-1:0];
                sqy_reg[k] <= sqy[k][2*C-1:0];
            end
            for (int c = 0; c < 3; c++)
            begin
                dxx_reg[c] <= dxx[c];
                dyy_reg[c] <= dyy[c];
            end
            cnt3_reg    <= cnt2_reg;
            kind3_reg   <= kind2_reg;
            area3_reg   <= s_abs[2*C+1:0];
            convex3_reg <= convex_c;
            dot3_reg    <= dot_c;
            len3_reg    <= len_c;
        end
    end

    // The outline is convex when all four turns are nonzero and share one sign.
    always_comb
    begin
        logic signed [SW-1:0] cr;
        logic signed [SW-1:0] ds;
        logic                 all_pos;
        logic                 all_neg;
        s_sum   = '0;
        all_pos = 1'b1;
        all_neg = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            s_sum = s_sum + $signed(SW'(spa_reg[k])) - $signed(SW'(spb_reg[k]));
            cr = SW'(cpa_reg[k]) - SW'(cpb_reg[k]);
            all_pos = all_pos && !cr[SW-1] && (cr != '0);
            all_neg = all_neg && cr[SW-1];
        end
        s_abs    = s_sum[SW-1] ? -s_sum : s_sum;
        convex_c = all_pos || all_neg;
        for (int c = 0; c < 3; c++)
        begin
            ds = SW'(dxx_reg[c]) + SW'(dyy_reg[c]);
            if (ds[SW-1])
            begin
                ds = -ds;
            end
            dot_c[c] = ds[LW-1:0];
        end
        for (int k = 0; k < 4; k++)
        begin
            len_c[k] = LW'(sqx_reg[k]) + LW'(sqy_reg[k]);
        end
    end

    assign out_valid = v3_reg;
    assign count_ok  = cnt3_reg;
    assign kind      = kind3_reg;
    assign area_abs  = area3_reg;
    assign convex    = convex3_reg;
    assign dot_abs   = dot3_reg;
    assign len_sq    = len3_reg;

endmodule

### sv/qsc_fifo.sv
// ---------------------------------------------------------------------------
// qsc_fifo: small decoupling queue between front end and back end
// Register-based FIFO; depth must be a power of two.
// ---------------------------------------------------------------------------
module qsc_fifo
    import qsc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != NW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### sv/qsc_back.sv
// ---------------------------------------------------------------------------
// qsc_back: decision back end
// Squares the limits, scales them by the geometry over split partial
// products, and makes the final exact comparisons into the output register.
// ---------------------------------------------------------------------------
module qsc_back
    import qsc_pkg::*;
#(
    parameter int C = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  qsc_cfg_t            cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                count_ok,
    input  logic [1:0]          kind,
    input  logic [2*C+1:0]      area_abs,
    input  logic                convex,
    input  logic [2:0][2*C:0]   dot_abs,
    input  logic [3:0][2*C:0]   len_sq,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                is_match,
    output logic                area_ok,
    output logic                convex_ok,
    output logic                corners_ok,
    output logic                ratio_ok
);

    localparam int LW  = 2 * C + 1;
    localparam int AW  = (2 * C + 2 > AREA_W + 1) ? 2 * C + 2 : AREA_W + 1;
    localparam int CW  = 2 * LW + 2 * COS_W;
    localparam int R2W = 2 * RATIO_W;
    localparam int RW  = LW + R2W;

    logic en;
    logic v1_reg, v2_reg, v3_reg;

    // Stage 1 results
    logic [RATIO_W-1:0] r_lo, r_hi;
    logic               need_lo, kind_ok;
    logic [LW-1:0]      big_len, sml_len;

    logic                 cnt1_reg, area1_reg, convex1_reg, kind_ok1_reg, need_lo1_reg;
    logic [2*LW-1:0]      dsq1_reg [3];
    logic [2*LW-1:0]      pl1_reg [3];
    logic [2*COS_W-1:0]   cl2_reg;
    logic [R2W-1:0]       rlo2_reg, rhi2_reg;
    logic [LW-1:0]        big1_reg, sml1_reg;

    // Stage 2 partial products
    logic                    cnt2_reg, area2_reg, convex2_reg, kind_ok2_reg, need_lo2_reg;
    logic [2*LW-1:0]         dsq2_reg [3];
    logic [2*COS_W+LW-1:0]   pc_lo_reg [3];
    logic [2*COS_W+LW-1:0]   pc_hi_reg [3];
    logic [RATIO_W+LW-1:0]   rl_lo_reg, rl_hi_reg, rh_lo_reg, rh_hi_reg;
    logic [LW-1:0]           big2_reg;

    logic corners_c, gt_lo, lt_hi, ratio_c;
    logic match_reg, area_reg, convex_reg, corners_reg, ratio_reg;

    assign en       = !v3_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        r_lo    = cfg.red_ratio_low;
        r_hi    = cfg.square_ratio_max;
        need_lo = 1'b0;
        kind_ok = 1'b1;
        unique case (kind)
            KIND_SQUARE:
            begin
                r_hi = cfg.square_ratio_max;
            end
            KIND_RED:
            begin
                r_lo    = cfg.red_ratio_low;
                r_hi    = cfg.red_ratio_high;
                need_lo = 1'b1;
            end
            KIND_GRAY:
            begin
                r_lo    = cfg.gray_ratio_low;
                r_hi    = cfg.gray_ratio_high;
                need_lo = 1'b1;
            end
            KIND_UNKNOWN:
            begin
                kind_ok = 1'b0;
            end
            default:
            begin
                kind_ok = 1'b0;
            end
        endcase
        if (len_sq[0] > len_sq[1])
        begin
            big_len = len_sq[0];
            sml_len = len_sq[1];
        end
        else
        begin
            big_len = len_sq[1];
            sml_len = len_sq[0];
        end
    end

    // Corner c sits at vertex c+1 between edges c and c+1.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt1_reg     <= count_ok;
            area1_reg    <= count_ok && (AW'(area_abs) > (AW'(cfg.min_area) << 1));
            convex1_reg  <= convex;
            kind_ok1_reg <= kind_ok;
            need_lo1_reg <= need_lo;
            for (int c = 0; c < 3; c++)
            begin
                dsq1_reg[c] <= dot_abs[c] * dot_abs[c];
                pl1_reg[c]  <= len_sq[c+1] * len_sq[c];
            end
            cl2_reg  <= cfg.cosine_limit * cfg.cosine_limit;
            rlo2_reg <= r_lo * r_lo;
            rhi2_reg <= r_hi * r_hi;
            big1_reg <= big_len;
            sml1_reg <= sml_len;

            cnt2_reg     <= cnt1_reg;
            area2_reg    <= area1_reg;
            convex2_reg  <= convex1_reg;
            kind_ok2_reg <= kind_ok1_reg;
            need_lo2_reg <= need_lo1_reg;
            for (int c = 0; c < 3; c++)
            begin
                dsq2_reg[c]  <= dsq1_reg[c];
                pc_lo_reg[c] <= cl2_reg * pl1_reg[c][LW-1:0];
                pc_hi_reg[c] <= cl2_reg * pl1_reg[c][2*LW-1:LW];
            end
            rl_lo_reg <= rlo2_reg[RATIO_W-1:0] * sml1_reg;
            rl_hi_reg <= rlo2_reg[R2W-1:RATIO_W] * sml1_reg;
            rh_lo_reg <= rhi2_reg[RATIO_W-1:0] * sml1_reg;
            rh_hi_reg <= rhi2_reg[R2W-1:RATIO_W] * sml1_reg;
            big2_reg  <= big1_reg;

            match_reg   <= area2_reg && cnt2_reg && convex2_reg && corners_c && ratio_c;
            area_reg    <= area2_reg;
            convex_reg  <= cnt2_reg && convex2_reg;
            corners_reg <= cnt2_reg && corners_c;
            ratio_reg   <= ratio_c;
        end
    end

    always_comb
    begin
        logic [CW-1:0] lhs_c, rhs_c;
        logic [RW-1:0] lhs_r, rhs_lo, rhs_hi;
        corners_c = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            lhs_c = CW'(dsq2_reg[c]) << FRAC2_SHIFT;
            rhs_c = (CW'(pc_hi_reg[c]) << LW) + CW'(pc_lo_reg[c]);
            corners_c = corners_c && (lhs_c < rhs_c);
        end
        lhs_r  = RW'(big2_reg) << FRAC2_SHIFT;
        rhs_lo = (RW'(rl_hi_reg) << RATIO_W) + RW'(rl_lo_reg);
        rhs_hi = (RW'(rh_hi_reg) << RATIO_W) + RW'(rh_lo_reg);
        gt_lo  = lhs_r > rhs_lo;
        lt_hi  = lhs_r < rhs_hi;
        ratio_c = cnt2_reg && kind_ok2_reg && (!need_lo2_reg || gt_lo) && lt_hi;
    end

    assign out_valid  = v3_reg;
    assign is_match   = match_reg;
    assign area_ok    = area_reg;
    assign convex_ok  = convex_reg;
    assign corners_ok = corners_reg;
    assign ratio_ok   = ratio_reg;

endmodule

### dv/tb_pkg.sv
// ---------------------------------------------------------------------------
// tb_pkg: shared types for the quad shape classifier testbench
// Contour and verdict records passed between stimulus, driver and monitor.
// ---------------------------------------------------------------------------
package tb_pkg;

    typedef struct {
        logic [3:0]  vertex_count;
        logic [1:0]  shape_kind;
        logic [11:0] x [4];
        logic [11:0] y [4];
    } contour_t;

    typedef struct packed {
        logic is_match;
        logic area_ok;
        logic convex_ok;
        logic corners_ok;
        logic ratio_ok;
    } verdict_t;

endpackage

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking testbench for quad_shape_classifier
// Drives contours through the valid/ready channels with random gaps, predicts
// each verdict with exact wide integer arithmetic and compares in order.
// ---------------------------------------------------------------------------
module tb;
    import qsc_pkg::*;
    import tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    qsc_in_if  #(.COORD_BITS(12)) in_ch();
    qsc_out_if out_ch();
    qsc_cfg_if cfg_ch();

    quad_shape_classifier #(.COORD_BITS(12)) u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    qsc_cfg_t   shadow_cfg;
    contour_t   pending_contours[$];
    verdict_t   expected_verdicts[$];
    int         error_count;
    int         cycle_count;
    bit         quiet_phase;
    bit         in_taken;
    int         send_gap;
    int         recv_gap;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("tb: mismatch %s", what);
        error_count++;
    endtask

    function automatic void queue_contour(input contour_t c);
        pending_contours.insert(pending_contours.size(), c);
    endfunction

    function automatic logic [63:0] abs_val(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // The squared ratio test: big*2^32 against r^2*small.
    function automatic int compare_ratio(input logic [63:0] big, input logic [63:0] small_len,
                                         input logic [19:0] r);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = {64'd0, big} << FRAC2_SHIFT;
        rhs = 128'(r) * 128'(r) * 128'(small_len);
        if (lhs < rhs) return -1;
        if (lhs > rhs) return 1;
        return 0;
    endfunction

    function automatic bit corner_passes(input contour_t c, input int a, input int b,
                                         input int k);
        logic signed [63:0] dx1, dy1, dx2, dy2;
        logic [63:0]        d;
        logic [191:0]       lhs;
        logic [191:0]       rhs;
        dx1 = $signed({52'd0, c.x[a]}) - $signed({52'd0, c.x[k]});
        dy1 = $signed({52'd0, c.y[a]}) - $signed({52'd0, c.y[k]});
        dx2 = $signed({52'd0, c.x[b]}) - $signed({52'd0, c.x[k]});
        dy2 = $signed({52'd0, c.y[b]}) - $signed({52'd0, c.y[k]});
        d = abs_val(dx1 * dx2 + dy1 * dy2);
        lhs = (192'(d) * 192'(d)) << FRAC2_SHIFT;
        rhs = 192'(dx1 * dx1 + dy1 * dy1) * 192'(dx2 * dx2 + dy2 * dy2)
              * 192'(shadow_cfg.cosine_limit) * 192'(shadow_cfg.cosine_limit);
        return lhs < rhs;
    endfunction

    function automatic verdict_t classify_contour(input contour_t c);
        verdict_t           v;
        logic signed [63:0] xs[4], ys[4];
        logic signed [63:0] s, cr, l1, l2;
        int                 sgn, sg, p, n;
        logic [63:0]        big, small_len;
        v = '0;
        if (c.vertex_count != 4'd4) return v;
        for (int i = 0; i < 4; i++)
        begin
            xs[i] = $signed({52'd0, c.x[i]});
            ys[i] = $signed({52'd0, c.y[i]});
        end
        s = 0;
        for (int i = 0; i < 4; i++)
            s += xs[i] * ys[(i + 1) % 4] - xs[(i + 1) % 4] * ys[i];
        v.area_ok = abs_val(s) > 2 * 64'(shadow_cfg.min_area);
        v.convex_ok = 1'b1;
        sgn = 0;
        for (int i = 0; i < 4; i++)
        begin
            p = (i + 3) % 4;
            n = (i + 1) % 4;
            cr = (xs[i] - xs[p]) * (ys[n] - ys[i]) - (ys[i] - ys[p]) * (xs[n] - xs[i]);
            sg = cr > 0 ? 1 : (cr < 0 ? -1 : 0);
            if (sg == 0 || (sgn != 0 && sg != sgn)) v.convex_ok = 1'b0;
            sgn = sg;
        end
        v.corners_ok = corner_passes(c, 2, 0, 1) && corner_passes(c, 3, 1, 2)
                       && corner_passes(c, 0, 2, 3);
        l1 = (xs[1] - xs[0]) * (xs[1] - xs[0]) + (ys[1] - ys[0]) * (ys[1] - ys[0]);
        l2 = (xs[2] - xs[1]) * (xs[2] - xs[1]) + (ys[2] - ys[1]) * (ys[2] - ys[1]);
        big = l1 > l2 ? l1 : l2;
        small_len = l1 > l2 ? l2 : l1;
        case (c.shape_kind)
            KIND_SQUARE:
                v.ratio_ok = compare_ratio(big, small_len, shadow_cfg.square_ratio_max) < 0;
            KIND_RED:
                v.ratio_ok = compare_ratio(big, small_len, shadow_cfg.red_ratio_low) > 0
                             && compare_ratio(big, small_len, shadow_cfg.red_ratio_high) < 0;
            KIND_GRAY:
                v.ratio_ok = compare_ratio(big, small_len, shadow_cfg.gray_ratio_low) > 0
                             && compare_ratio(big, small_len, shadow_cfg.gray_ratio_high) < 0;
            default:
                v.ratio_ok = 1'b0;
        endcase
        v.is_match = v.area_ok && v.convex_ok && v.corners_ok && v.ratio_ok;
        return v;
    endfunction

    // Driver: presents the oldest pending contour and holds it until it is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_contours.size() > 0)
                begin
                    if (!quiet_phase && $urandom_range(0, 5) == 0)
                    begin
                        send_gap = $urandom_range(1, 7) - 1;
                        in_ch.valid <= 1'b0;
                    end
                    else
                    begin
                        in_ch.valid        <= 1'b1;
                        in_ch.vertex_count <= pending_contours[0].vertex_count;
                        in_ch.shape_kind   <= pending_contours[0].shape_kind;
                        in_ch.x0 <= pending_contours[0].x[0];
                        in_ch.y0 <= pending_contours[0].y[0];
                        in_ch.x1 <= pending_contours[0].x[1];
                        in_ch.y1 <= pending_contours[0].y[1];
                        in_ch.x2 <= pending_contours[0].x[2];
                        in_ch.y2 <= pending_contours[0].y[2];
                        in_ch.x3 <= pending_contours[0].x[3];
                        in_ch.y3 <= pending_contours[0].y[3];
                    end
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // The contour is retired and predicted at the accepting edge.
    always @(posedge clk)
    begin
        contour_t c;
        in_taken = 1'b0;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            c = pending_contours.pop_front();
            expected_verdicts.insert(expected_verdicts.size(), classify_contour(c));
            in_taken = 1'b1;
        end
    end

    // Receiver back-pressure in random bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(1, 7) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t exp_v;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.is_match, out_ch.area_ok, out_ch.convex_ok,
                   out_ch.corners_ok, out_ch.ratio_ok};
            if (expected_verdicts.size() == 0)
                report_mismatch("unexpected result transaction");
            else
            begin
                exp_v = expected_verdicts.pop_front();
                if (got.is_match !== exp_v.is_match)
                    report_mismatch($sformatf("is_match %b exp %b", got.is_match, exp_v.is_match));
                if (got.area_ok !== exp_v.area_ok)
                    report_mismatch($sformatf("area_ok %b exp %b", got.area_ok, exp_v.area_ok));
                if (got.convex_ok !== exp_v.convex_ok)
                    report_mismatch($sformatf("convex_ok %b exp %b",
                                              got.convex_ok, exp_v.convex_ok));
                if (got.corners_ok !== exp_v.corners_ok)
                    report_mismatch($sformatf("corners_ok %b exp %b",
                                              got.corners_ok, exp_v.corners_ok));
                if (got.ratio_ok !== exp_v.ratio_ok)
                    report_mismatch($sformatf("ratio_ok %b exp %b",
                                              got.ratio_ok, exp_v.ratio_ok));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic write_register(input logic [2:0] idx, input logic [23:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            REG_MIN_AREA:     shadow_cfg.min_area         = value;
            REG_COSINE_LIMIT: shadow_cfg.cosine_limit     = value[15:0];
            REG_SQUARE_MAX:   shadow_cfg.square_ratio_max = value[19:0];
            REG_RED_LOW:      shadow_cfg.red_ratio_low    = value[19:0];
            REG_RED_HIGH:     shadow_cfg.red_ratio_high   = value[19:0];
            REG_GRAY_LOW:     shadow_cfg.gray_ratio_low   = value[19:0];
            REG_GRAY_HIGH:    shadow_cfg.gray_ratio_high  = value[19:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_pipeline();
        while (pending_contours.size() > 0 || expected_verdicts.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic contour_t make_rect(input int cx, input int cy, input int w,
                                           input int h, input logic [1:0] kind);
        contour_t c;
        c.vertex_count = 4'd4;
        c.shape_kind = kind;
        c.x[0] = 12'(cx);     c.y[0] = 12'(cy);
        c.x[1] = 12'(cx + w); c.y[1] = 12'(cy);
        c.x[2] = 12'(cx + w); c.y[2] = 12'(cy + h);
        c.x[3] = 12'(cx);     c.y[3] = 12'(cy + h);
        return c;
    endfunction

    function automatic contour_t random_contour();
        contour_t c;
        int       w, h, cx, cy, sel, jit;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            // Near-rectangles, with a ratio drawn toward the kind bands.
            w = $urandom_range(8, 900);
            case ($urandom_range(0, 3))
                0: h = w + $urandom_range(0, w / 4 + 1);
                1: h = (w * $urandom_range(125, 155)) / 100;
                2: h = (w * $urandom_range(195, 225)) / 100;
                default: h = $urandom_range(8, 1800);
            endcase
            if (h > 2000) h = 2000;
            cx = $urandom_range(0, 4095 - w);
            cy = $urandom_range(0, 4095 - h);
            c = make_rect(cx, cy, w, h, 2'($urandom_range(0, 3)));
            jit = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            for (int i = 0; i < 4; i++)
            begin
                c.x[i] = 12'(int'(c.x[i]) + (jit == 0 ? 0 :
                        (c.x[i] > 12 && c.x[i] < 4083 ? $urandom_range(0, 2 * jit) - jit : 0)));
                c.y[i] = 12'(int'(c.y[i]) + (jit == 0 ? 0 :
                        (c.y[i] > 12 && c.y[i] < 4083 ? $urandom_range(0, 2 * jit) - jit : 0)));
            end
            if ($urandom_range(0, 19) == 0) c.vertex_count = 4'($urandom_range(0, 15));
        end
        else
        begin
            c.vertex_count = sel < 9 ? 4'd4 : 4'($urandom_range(0, 15));
            c.shape_kind = 2'($urandom_range(0, 3));
            for (int i = 0; i < 4; i++)
            begin
                c.x[i] = 12'($urandom);
                c.y[i] = 12'($urandom);
            end
        end
        return c;
    endfunction

    initial
    begin
        contour_t c;
        error_count = 0;
        cycle_count = 0;
        quiet_phase = 1'b0;
        in_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.vertex_count = '0;
        in_ch.shape_kind = '0;
        {in_ch.x0, in_ch.y0, in_ch.x1, in_ch.y1} = '0;
        {in_ch.x2, in_ch.y2, in_ch.x3, in_ch.y3} = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        shadow_cfg = '{RST_MIN_AREA, RST_COSINE_LIMIT, RST_SQUARE_MAX, RST_RED_LOW,
                       RST_RED_HIGH, RST_GRAY_LOW, RST_GRAY_HIGH};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed contours under reset settings.
        queue_contour(make_rect(100, 100, 200, 200, KIND_SQUARE));
        queue_contour(make_rect(100, 100, 200, 280, KIND_RED));
        queue_contour(make_rect(100, 100, 200, 420, KIND_GRAY));
        queue_contour(make_rect(100, 100, 200, 200, KIND_UNKNOWN));
        queue_contour(make_rect(0, 0, 4095, 4095, KIND_SQUARE));
        queue_contour(make_rect(10, 10, 20, 20, KIND_SQUARE));
        c = make_rect(100, 100, 200, 200, KIND_SQUARE);
        c.vertex_count = 4'd3;
        queue_contour(c);
        c.vertex_count = 4'd15;
        queue_contour(c);
        c.vertex_count = 4'd0;
        queue_contour(c);
        // Zero-length side and a bow-tie outline.
        c = make_rect(100, 100, 200, 200, KIND_SQUARE);
        c.x[1] = c.x[0];
        c.y[1] = c.y[0];
        queue_contour(c);
        c = make_rect(100, 100, 200, 200, KIND_RED);
        c.x[2] = 12'd100;
        c.x[3] = 12'd300;
        queue_contour(c);
        // Counter-clockwise outline and a rhombus.
        c = make_rect(500, 500, 300, 300, KIND_SQUARE);
        c.x = '{12'd500, 12'd500, 12'd800, 12'd800};
        c.y = '{12'd500, 12'd800, 12'd800, 12'd500};
        queue_contour(c);
        c.x = '{12'd1000, 12'd1300, 12'd1000, 12'd700};
        c.y = '{12'd500, 12'd800, 12'd1100, 12'd800};
        queue_contour(c);
        c.x = '{12'd4095, 12'd0, 12'd4095, 12'd0};
        c.y = '{12'd0, 12'd4095, 12'd4095, 12'd0};
        queue_contour(c);
        drain_pipeline();

        // Extreme settings: zero area and cosine limits, then the maxima.
        write_register(REG_MIN_AREA, 24'd0);
        write_register(REG_COSINE_LIMIT, 24'd0);
        write_register(REG_SQUARE_MAX, 24'd65536);
        write_register(REG_RED_LOW, 24'd65536);
        write_register(REG_RED_HIGH, 24'hFFFFF);
        write_register(REG_GRAY_LOW, 24'd65536);
        write_register(REG_GRAY_HIGH, 24'hFFFFF);
        for (int i = 0; i < 150; i++) queue_contour(random_contour());
        drain_pipeline();

        write_register(REG_MIN_AREA, 24'hFFFFFF);
        write_register(REG_COSINE_LIMIT, 24'hFFFF);
        write_register(REG_SQUARE_MAX, 24'hFFFFF);
        for (int i = 0; i < 150; i++) queue_contour(random_contour());
        drain_pipeline();

        // Random settings phases.
        for (int ph = 0; ph < 3; ph++)
        begin
            write_register(REG_MIN_AREA, 24'($urandom_range(0, 200000)));
            write_register(REG_COSINE_LIMIT, 24'($urandom_range(0, 65535)));
            write_register(REG_SQUARE_MAX, 24'($urandom_range(65536, 100000)));
            write_register(REG_RED_LOW, 24'($urandom_range(65536, 95000)));
            write_register(REG_RED_HIGH, 24'($urandom_range(90000, 120000)));
            write_register(REG_GRAY_LOW, 24'($urandom_range(120000, 140000)));
            write_register(REG_GRAY_HIGH, 24'($urandom_range(135000, 160000)));
            for (int i = 0; i < 150; i++) queue_contour(random_contour());
            drain_pipeline();
        end

        // Back to the reset values, with gaps turned off at the end.
        write_register(REG_MIN_AREA, RST_MIN_AREA);
        write_register(REG_COSINE_LIMIT, 24'(RST_COSINE_LIMIT));
        write_register(REG_SQUARE_MAX, 24'(RST_SQUARE_MAX));
        write_register(REG_RED_LOW, 24'(RST_RED_LOW));
        write_register(REG_RED_HIGH, 24'(RST_RED_HIGH));
        write_register(REG_GRAY_LOW, 24'(RST_GRAY_LOW));
        write_register(REG_GRAY_HIGH, 24'(RST_GRAY_HIGH));
        for (int i = 0; i < 330; i++) queue_contour(random_contour());
        while (pending_contours.size() > 50) @(posedge clk);
        quiet_phase = 1'b1;
        drain_pipeline();

        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
